[design/distance_vector_table_update_assert.svh]
// Assertion macros shared by the routing table modules.
`ifndef DISTANCE_VECTOR_TABLE_UPDATE_ASSERT_SVH
`define DISTANCE_VECTOR_TABLE_UPDATE_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define DVT_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define DVT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[design/dvt_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package dvt_pkg;

  localparam int NODES_DEF = 16;
  localparam int DIST_W    = 31;
  localparam int IDX_W     = 4;
  localparam int CMD_W     = 2;

  localparam logic [DIST_W-1:0] DIST_INF = {DIST_W{1'b1}};

  localparam logic [CMD_W-1:0] CMD_LOAD     = 2'd0;
  localparam logic [CMD_W-1:0] CMD_NEIGHBOR = 2'd1;
  localparam logic [CMD_W-1:0] CMD_READ     = 2'd2;
  localparam logic [CMD_W-1:0] CMD_CLEAR    = 2'd3;

  typedef struct packed {
    logic capture;
    logic exec;
  } dvt_cmd_t;

endpackage

`default_nettype wire

[design/dvt_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none

`include "distance_vector_table_update_assert.svh"

module dvt_ctrl (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           start,
  output logic                busy,
  output logic                done_o,
  output dvt_pkg::dvt_cmd_t   cmd_o
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EXEC = 1'b1;

  logic state_q, state_d;
  logic done_q;

  always_comb begin
    cmd_o.capture = 1'b0;
    cmd_o.exec    = 1'b0;
    state_d       = state_q;
    case (state_q)
      ST_IDLE: begin
        if (start) begin
          cmd_o.capture = 1'b1;
          state_d       = ST_EXEC;
        end
      end
      ST_EXEC: begin
        cmd_o.exec = 1'b1;
        state_d    = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= cmd_o.exec;
    end
  end

  assign busy   = (state_q == ST_EXEC);
  assign done_o = done_q;

  `DVT_ASSERT_NEXT(a_capture_to_exec, cmd_o.capture, cmd_o.exec, "capture not followed by exec")
  `DVT_ASSERT_NEXT(a_exec_to_done, cmd_o.exec, done_o && !busy, "exec not followed by result")
  `DVT_ASSERT_SAME(a_no_capture_busy, cmd_o.capture, !busy, "item captured while busy")

endmodule

`default_nettype wire

[design/dvt_datapath.sv]
`timescale 1ns / 1ps
`default_nettype none

`include "distance_vector_table_update_assert.svh"

module dvt_datapath #(
  parameter int NODES = dvt_pkg::NODES_DEF
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire dvt_pkg::dvt_cmd_t           cmd_i,
  input  wire logic [dvt_pkg::CMD_W-1:0]   command_i,
  input  wire logic [dvt_pkg::IDX_W-1:0]   neighbor_index_i,
  input  wire logic [dvt_pkg::IDX_W-1:0]   dest_index_i,
  input  wire logic [dvt_pkg::DIST_W-1:0]  distance_i,
  output logic                             changed_o,
  output logic [dvt_pkg::DIST_W-1:0]       dist_out_o,
  output logic [dvt_pkg::IDX_W-1:0]        next_hop_o,
  output logic                             modified_o
);

  localparam int AW = (NODES > 1) ? $clog2(NODES) : 1;

  logic [dvt_pkg::DIST_W-1:0] dist_mem [NODES];
  logic [dvt_pkg::IDX_W-1:0]  hop_mem  [NODES];
  logic [NODES-1:0]           valid_q;

  logic [31:0]   nb_ext, dst_ext;
  logic [AW-1:0] nb_addr, dst_addr;
  logic          nb_ok, dst_ok;

  logic [dvt_pkg::CMD_W-1:0]  cmd_q;
  logic [dvt_pkg::IDX_W-1:0]  dst_idx_q;
  logic [AW-1:0]              dst_addr_q;
  logic                       nb_ok_q, dst_ok_q;
  logic                       nb_vld_q, dst_vld_q;
  logic [dvt_pkg::DIST_W-1:0] dist_q;
  logic [dvt_pkg::DIST_W-1:0] nb_dist_q, dst_dist_q;
  logic [dvt_pkg::IDX_W-1:0]  nb_hop_q, dst_hop_q;

  logic                       flag_q, flag_d;
  logic [dvt_pkg::DIST_W-1:0] nd, dd, sum_sat;
  logic [dvt_pkg::IDX_W-1:0]  nh, dh;
  logic [dvt_pkg::DIST_W:0]   sum;
  logic                       is_load, improve, wr_en;
  logic [dvt_pkg::DIST_W-1:0] wr_dist, res_dist;
  logic [dvt_pkg::IDX_W-1:0]  wr_hop, res_hop;

  logic                       changed_q;
  logic [dvt_pkg::DIST_W-1:0] dist_out_q;
  logic [dvt_pkg::IDX_W-1:0]  next_hop_q;
  logic                       modified_q;

  assign nb_ext   = 32'(neighbor_index_i);
  assign dst_ext  = 32'(dest_index_i);
  assign nb_addr  = nb_ext[AW-1:0];
  assign dst_addr = dst_ext[AW-1:0];
  assign nb_ok    = (nb_ext < 32'(NODES));
  assign dst_ok   = (dst_ext < 32'(NODES));

  // Both table reads are launched when the item is captured.
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      cmd_q      <= command_i;
      dst_idx_q  <= dest_index_i;
      dst_addr_q <= dst_addr;
      dist_q     <= distance_i;
      nb_dist_q  <= dist_mem[nb_addr];
      nb_hop_q   <= hop_mem[nb_addr];
      dst_dist_q <= dist_mem[dst_addr];
      dst_hop_q  <= hop_mem[dst_addr];
    end
    if (wr_en) begin
      dist_mem[dst_addr_q] <= wr_dist;
      hop_mem[dst_addr_q]  <= wr_hop;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      nb_ok_q    <= 1'b0;
      dst_ok_q   <= 1'b0;
      nb_vld_q   <= 1'b0;
      dst_vld_q  <= 1'b0;
      flag_q     <= 1'b0;
      changed_q  <= 1'b0;
      modified_q <= 1'b0;
    end else begin
      if (cmd_i.capture) begin
        nb_ok_q   <= nb_ok;
        dst_ok_q  <= dst_ok;
        nb_vld_q  <= nb_ok && valid_q[nb_addr];
        dst_vld_q <= dst_ok && valid_q[dst_addr];
      end
      if (wr_en) begin
        valid_q[dst_addr_q] <= 1'b1;
      end
      if (cmd_i.exec) begin
        flag_q     <= flag_d;
        changed_q  <= improve;
        modified_q <= flag_d;
      end
    end
  end

  // Entries never written read as infinity with next hop zero.
  always_comb begin
    nd = (nb_ok_q && nb_vld_q) ? nb_dist_q : dvt_pkg::DIST_INF;
    nh = (nb_ok_q && nb_vld_q) ? nb_hop_q : '0;
    dd = dst_vld_q ? dst_dist_q : dvt_pkg::DIST_INF;
    dh = dst_vld_q ? dst_hop_q : '0;

    sum = {1'b0, nd} + {1'b0, dist_q};
    if ((nd == dvt_pkg::DIST_INF) || (dist_q == dvt_pkg::DIST_INF) ||
        (sum >= {1'b0, dvt_pkg::DIST_INF})) begin
      sum_sat = dvt_pkg::DIST_INF;
    end else begin
      sum_sat = sum[dvt_pkg::DIST_W-1:0];
    end

    is_load = dst_ok_q && (cmd_q == dvt_pkg::CMD_LOAD);
    improve = dst_ok_q && (cmd_q == dvt_pkg::CMD_NEIGHBOR) &&
              (sum_sat != dvt_pkg::DIST_INF) && (sum_sat < dd);
    wr_en   = cmd_i.exec && (is_load || improve);
    wr_dist = is_load ? dist_q : sum_sat;
    wr_hop  = is_load ? dst_idx_q : nh;

    if (!dst_ok_q) begin
      res_dist = dvt_pkg::DIST_INF;
      res_hop  = '0;
    end else if (is_load || improve) begin
      res_dist = wr_dist;
      res_hop  = wr_hop;
    end else begin
      res_dist = dd;
      res_hop  = dh;
    end

    flag_d = flag_q;
    if (improve) begin
      flag_d = 1'b1;
    end else if (dst_ok_q && (cmd_q == dvt_pkg::CMD_CLEAR)) begin
      flag_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      dist_out_q <= res_dist;
      next_hop_q <= res_hop;
    end
  end

  assign changed_o  = changed_q;
  assign dist_out_o = dist_out_q;
  assign next_hop_o = next_hop_q;
  assign modified_o = modified_q;

  `DVT_ASSERT_SAME(a_changed_sets_flag, changed_o, modified_o, "change without modified flag")
  `DVT_ASSERT_NEXT(a_improve_flag, cmd_i.exec && improve, flag_q, "flag not set on improvement")
  `DVT_ASSERT_NEXT(a_clear_drops_flag, cmd_i.exec && dst_ok_q && (cmd_q == dvt_pkg::CMD_CLEAR), !modified_o && !changed_o, "flag not cleared")

endmodule

`default_nettype wire

[design/distance_vector_table_update.sv]
// Distance-vector routing table with one relaxation step per item. An item is
// taken when start is high and busy is low; its result is shown on the outputs
// for exactly one cycle with done_o high, once the item has been captured and
// executed, and the receiver cannot hold it off. Each item is handled in a
// read step, which reads the neighbor and destination entries from the
// two-read-port table, and an add, compare and write-back step, so busy is high
// for the single cycle of the write-back step.
// A new item may be accepted in the cycle its predecessor's result is shown.
`timescale 1ns / 1ps
`default_nettype none

module distance_vector_table_update #(
  parameter int NODES = dvt_pkg::NODES_DEF
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        start,
  output logic                             busy,
  input  wire logic [dvt_pkg::CMD_W-1:0]   command_i,
  input  wire logic [dvt_pkg::IDX_W-1:0]   neighbor_index_i,
  input  wire logic [dvt_pkg::IDX_W-1:0]   dest_index_i,
  input  wire logic [dvt_pkg::DIST_W-1:0]  distance_i,
  output logic                             done_o,
  output logic                             changed_o,
  output logic [dvt_pkg::DIST_W-1:0]       dist_out_o,
  output logic [dvt_pkg::IDX_W-1:0]        next_hop_o,
  output logic                             modified_o
);

  dvt_pkg::dvt_cmd_t cmd;

  dvt_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .done_o (done_o),
    .cmd_o  (cmd)
  );

  dvt_datapath #(
    .NODES (NODES)
  ) u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .command_i        (command_i),
    .neighbor_index_i (neighbor_index_i),
    .dest_index_i     (dest_index_i),
    .distance_i       (distance_i),
    .changed_o        (changed_o),
    .dist_out_o       (dist_out_o),
    .next_hop_o       (next_hop_o),
    .modified_o       (modified_o)
  );

endmodule

`default_nettype wire
